// ===== design/file_descriptor_table_assert.svh =====
// Assertion macros used by the file descriptor table top level.
`ifndef FILE_DESCRIPTOR_TABLE_ASSERT_SVH
`define FILE_DESCRIPTOR_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge while reset is released.
`define FDT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define FDT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDT_ASSERT(label, prop, msg)
`define FDT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== design/fdt_pkg.sv =====
// Shared types, constants and a helper function of the file descriptor table.
`timescale 1ns / 1ps

package fdt_pkg;

    localparam int FILE_ENTRIES = 64;
    localparam int DESCRIPTORS  = 32;
    localparam int ENTRY_W      = $clog2(FILE_ENTRIES);
    localparam int SLOT_W       = $clog2(DESCRIPTORS);

    localparam int INODE_W  = 16;
    localparam int REFS_W   = 16;
    localparam int OFFSET_W = 32;
    localparam int ACC_W    = 3;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    // Access flag bit positions.
    localparam int ACC_READ_BIT   = 0;
    localparam int ACC_WRITE_BIT  = 1;
    localparam int ACC_APPEND_BIT = 2;

    // Operation codes.
    typedef enum logic [2:0] {
        FUNC_LOOKUP = 3'd0,
        FUNC_OPEN   = 3'd1,
        FUNC_BIND   = 3'd2,
        FUNC_DUP    = 3'd3,
        FUNC_PUT    = 3'd4,
        FUNC_CLOSE  = 3'd5,
        FUNC_CLEAR  = 3'd6
    } func_t;

    // Open mode codes; the upper two both mean read and write.
    localparam logic [1:0] MODE_RDONLY   = 2'd0;
    localparam logic [1:0] MODE_WRONLY   = 2'd1;
    localparam logic [1:0] MODE_RDWR     = 2'd2;
    localparam logic [1:0] MODE_RDWR_ALT = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_BADF  = 3'd1;
    localparam logic [2:0] ST_NFILE = 3'd2;
    localparam logic [2:0] ST_MFILE = 3'd3;
    localparam logic [2:0] ST_INVAL = 3'd4;

    // One file table entry as stored in the entry memory.
    typedef struct packed {
        logic [INODE_W-1:0]  inode;
        logic [REFS_W-1:0]   refs;
        logic [OFFSET_W-1:0] offset;
        logic [ACC_W-1:0]    acc;
    } entry_rec_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } fdt_cmd_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctl_state_t;

    function automatic logic [ACC_W-1:0] decode_access(input logic [1:0] mode,
                                                       input logic app);
        logic [ACC_W-1:0] acc;
        acc = '0;
        case (mode) inside
            MODE_RDONLY: acc[ACC_READ_BIT] = 1'b1;
            MODE_WRONLY: acc[ACC_WRITE_BIT] = 1'b1;
            MODE_RDWR, MODE_RDWR_ALT:
            begin
                acc[ACC_READ_BIT]  = 1'b1;
                acc[ACC_WRITE_BIT] = 1'b1;
            end
            default: acc = '0;
        endcase
        acc[ACC_APPEND_BIT] = app;
        return acc;
    endfunction

endpackage

// ===== design/file_descriptor_table.sv =====
// Top level of the file descriptor table: controller plus datapath.
// An accepted beat is captured, then processed in the execute cycle; its result and done are registered.
// A new beat is accepted only when idle, not while the block is busy executing the last one.
// The receiver cannot stall; each result beat is shown for one cycle, marked by done.
// Reset (rst_n, asynchronous) clears the in-use, row-valid and slot bitmaps; no sweep needed.
`timescale 1ns / 1ps
`include "file_descriptor_table_assert.svh"

module file_descriptor_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [7:0]  fd,
    input  logic [5:0]  entry,
    input  logic        entry_given,
    input  logic [15:0] inode_id,
    input  logic [1:0]  open_mode,
    input  logic        append,
    input  logic [31:0] file_size,
    output logic        done,
    output logic [2:0]  status,
    output logic [4:0]  fd_out,
    output logic [5:0]  entry_out,
    output logic [15:0] inode_out,
    output logic [31:0] offset_out,
    output logic        can_read,
    output logic        can_write,
    output logic        append_mode,
    output logic [15:0] ref_count,
    output logic        release_inode
);

    // The controller walks each operation through two phases. In the capture
    // cycle the datapath latches the request, picks the memory address (the
    // first free entry for open, the mapped entry for lookup, the given entry
    // otherwise) and starts the entry read. In the execute cycle it checks the
    // request against the read row and the bitmaps, writes the updated row
    // back and loads the result registers.
    fdt_pkg::fdt_cmd_t cmd;

    fdt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Rows that were never written, or were freed, read as all zero through
    // the row-valid bitmap, so the entry memory itself needs no reset.
    fdt_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .func          (func),
        .fd            (fd),
        .entry         (entry),
        .entry_given   (entry_given),
        .inode_id      (inode_id),
        .open_mode     (open_mode),
        .append        (append),
        .file_size     (file_size),
        .status        (status),
        .fd_out        (fd_out),
        .entry_out     (entry_out),
        .inode_out     (inode_out),
        .offset_out    (offset_out),
        .can_read      (can_read),
        .can_write     (can_write),
        .append_mode   (append_mode),
        .ref_count     (ref_count),
        .release_inode (release_inode)
    );

    // An accepted beat always moves the block into its execute cycle.
    `FDT_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted beat did not start work")
    // The execute cycle is always followed by exactly one result beat.
    `FDT_ASSERT(a_exec_done, busy |=> done && !busy, "execute cycle gave no result beat")
    // A result beat only ever follows an execute cycle.
    `FDT_ASSERT(a_done_past, done |-> $past(busy), "result beat without execute cycle")
    // After any edge taken while reset is held, the block is idle.
    `FDT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !busy && !cmd.execute, "busy during reset")

endmodule

// ===== design/fdt_ctrl.sv =====
// Controller state machine of the file descriptor table.
`timescale 1ns / 1ps

module fdt_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output fdt_pkg::fdt_cmd_t cmd,
    output logic             busy,
    output logic             done
);

    fdt_pkg::ctl_state_t state_reg;
    fdt_pkg::ctl_state_t state_next;
    logic                done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fdt_pkg::S_IDLE: if (start) state_next = fdt_pkg::S_EXEC;
            fdt_pkg::S_EXEC: state_next = fdt_pkg::S_IDLE;
            default:         state_next = fdt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        busy        = 1'b0;
        unique case (state_reg)
            fdt_pkg::S_IDLE: cmd.capture = start;
            fdt_pkg::S_EXEC:
            begin
                cmd.execute = 1'b1;
                busy        = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdt_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.execute;
        end
    end

    assign done = done_reg;

endmodule

// ===== design/fdt_datapath.sv =====
// Datapath of the file descriptor table: tables, entry memory and result registers.
`timescale 1ns / 1ps

module fdt_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  fdt_pkg::fdt_cmd_t cmd,
    input  logic [2:0]        func,
    input  logic [7:0]        fd,
    input  logic [5:0]        entry,
    input  logic              entry_given,
    input  logic [15:0]       inode_id,
    input  logic [1:0]        open_mode,
    input  logic              append,
    input  logic [31:0]       file_size,
    output logic [2:0]        status,
    output logic [4:0]        fd_out,
    output logic [5:0]        entry_out,
    output logic [15:0]       inode_out,
    output logic [31:0]       offset_out,
    output logic              can_read,
    output logic              can_write,
    output logic              append_mode,
    output logic [15:0]       ref_count,
    output logic              release_inode
);

    localparam int NE = fdt_pkg::FILE_ENTRIES;
    localparam int ND = fdt_pkg::DESCRIPTORS;
    localparam int EW = fdt_pkg::ENTRY_W;
    localparam int SW = fdt_pkg::SLOT_W;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  fd_out;
        logic [5:0]  entry_out;
        logic [15:0] inode_out;
        logic [31:0] offset_out;
        logic        can_read;
        logic        can_write;
        logic        append_mode;
        logic [15:0] ref_count;
        logic        release_inode;
    } res_t;

    // Control state: valid bits and slot map.
    logic [NE-1:0] in_use_reg, in_use_next;
    logic [NE-1:0] row_vld_reg, row_vld_next;
    logic [ND-1:0] slot_used_reg, slot_used_next;
    logic [EW-1:0] slot_entry_reg [ND];

    fdt_pkg::entry_rec_t mem [NE];
    fdt_pkg::entry_rec_t rd_rec_reg;

    // Captured operation.
    logic [2:0]  func_reg;
    logic [7:0]  fd_reg;
    logic [5:0]  entry_reg;
    logic        given_reg;
    logic [15:0] inode_reg;
    logic [1:0]  mode_reg;
    logic        app_reg;
    logic [31:0] size_reg;
    logic [EW-1:0] addr_reg;
    logic          free_found_reg;

    res_t res_reg, res_next;

    // Capture side: first free entry and the memory read address.
    logic [EW-1:0] free_idx;
    logic          free_found;
    logic [EW-1:0] rd_addr;

    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = NE - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_idx   = EW'(i);
                free_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (func)
            fdt_pkg::FUNC_OPEN:   rd_addr = free_idx;
            fdt_pkg::FUNC_LOOKUP: rd_addr = slot_entry_reg[fd[SW-1:0]];
            default:              rd_addr = EW'(entry);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg       <= func;
            fd_reg         <= fd;
            entry_reg      <= entry;
            given_reg      <= entry_given;
            inode_reg      <= inode_id;
            mode_reg       <= open_mode;
            app_reg        <= append;
            size_reg       <= file_size;
            addr_reg       <= rd_addr;
            free_found_reg <= free_found;
        end
    end

    // Execute side.
    logic [SW-1:0]       slot_idx;
    logic                slot_found;
    logic                slot_we;
    logic                mem_we;
    fdt_pkg::entry_rec_t wr_rec;
    fdt_pkg::entry_rec_t row;
    logic                fd_ok;
    logic                entry_ok;
    logic [15:0]         refs_dn;

    always_comb
    begin
        slot_idx   = '0;
        slot_found = 1'b0;
        for (int i = ND - 1; i >= 0; i--)
        begin
            if (!slot_used_reg[i])
            begin
                slot_idx   = SW'(i);
                slot_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        row      = row_vld_reg[addr_reg] ? rd_rec_reg : '0;
        fd_ok    = 32'(fd_reg) < ND;
        entry_ok = given_reg && (32'(entry_reg) < NE);
        refs_dn  = (row.refs != '0) ? row.refs - 16'd1 : '0;

        in_use_next    = in_use_reg;
        row_vld_next   = row_vld_reg;
        slot_used_next = slot_used_reg;
        slot_we        = 1'b0;
        mem_we         = 1'b0;
        wr_rec         = row;
        res_next       = '0;
        res_next.status = fdt_pkg::ST_INVAL;

        unique case (func_reg) inside
            fdt_pkg::FUNC_LOOKUP:
            begin
                res_next.status = fdt_pkg::ST_BADF;
                if (fd_ok && slot_used_reg[fd_reg[SW-1:0]] && in_use_reg[addr_reg]
                    && row.inode != '0)
                begin
                    res_next.status      = fdt_pkg::ST_OK;
                    res_next.entry_out   = 6'(addr_reg);
                    res_next.inode_out   = row.inode;
                    res_next.offset_out  = row.offset;
                    res_next.can_read    = row.acc[fdt_pkg::ACC_READ_BIT];
                    res_next.can_write   = row.acc[fdt_pkg::ACC_WRITE_BIT];
                    res_next.append_mode = row.acc[fdt_pkg::ACC_APPEND_BIT];
                    res_next.ref_count   = row.refs;
                end
            end
            fdt_pkg::FUNC_OPEN:
            begin
                if (inode_reg != '0)
                begin
                    res_next.status = fdt_pkg::ST_NFILE;
                    if (free_found_reg)
                    begin
                        wr_rec.inode  = inode_reg;
                        wr_rec.refs   = 16'd1;
                        wr_rec.offset = app_reg ? size_reg : '0;
                        wr_rec.acc    = fdt_pkg::decode_access(mode_reg, app_reg);
                        mem_we                 = 1'b1;
                        in_use_next[addr_reg]  = 1'b1;
                        row_vld_next[addr_reg] = 1'b1;
                        res_next.status      = fdt_pkg::ST_OK;
                        res_next.entry_out   = 6'(addr_reg);
                        res_next.inode_out   = wr_rec.inode;
                        res_next.offset_out  = wr_rec.offset;
                        res_next.can_read    = wr_rec.acc[fdt_pkg::ACC_READ_BIT];
                        res_next.can_write   = wr_rec.acc[fdt_pkg::ACC_WRITE_BIT];
                        res_next.append_mode = wr_rec.acc[fdt_pkg::ACC_APPEND_BIT];
                        res_next.ref_count   = wr_rec.refs;
                    end
                end
            end
            fdt_pkg::FUNC_BIND, fdt_pkg::FUNC_DUP:
            begin
                if (entry_ok)
                begin
                    if (!slot_found)
                    begin
                        res_next.status = fdt_pkg::ST_MFILE;
                    end
                    else
                    begin
                        slot_we                  = 1'b1;
                        slot_used_next[slot_idx] = 1'b1;
                        res_next.status          = fdt_pkg::ST_OK;
                        res_next.fd_out          = 5'(slot_idx);
                        if (func_reg == fdt_pkg::FUNC_DUP)
                        begin
                            // Dup counts up even on a free entry, and saturates.
                            if (row.refs != fdt_pkg::REFS_MAX)
                            begin
                                wr_rec.refs = row.refs + 16'd1;
                            end
                            mem_we                 = 1'b1;
                            row_vld_next[addr_reg] = 1'b1;
                            res_next.ref_count     = wr_rec.refs;
                        end
                    end
                end
            end
            fdt_pkg::FUNC_PUT, fdt_pkg::FUNC_CLOSE:
            begin
                if (entry_ok && (func_reg == fdt_pkg::FUNC_CLOSE || in_use_reg[addr_reg]))
                begin
                    res_next.status = fdt_pkg::ST_OK;
                    if (func_reg == fdt_pkg::FUNC_PUT && refs_dn != '0)
                    begin
                        wr_rec.refs        = refs_dn;
                        mem_we             = 1'b1;
                        res_next.ref_count = refs_dn;
                    end
                    else
                    begin
                        // Freeing an entry: an invalid row reads back as all zero.
                        in_use_next[addr_reg]  = 1'b0;
                        row_vld_next[addr_reg] = 1'b0;
                        if (row.inode != '0)
                        begin
                            res_next.inode_out     = row.inode;
                            res_next.release_inode = 1'b1;
                        end
                    end
                end
            end
            fdt_pkg::FUNC_CLEAR:
            begin
                res_next.status = fdt_pkg::ST_BADF;
                if (fd_ok)
                begin
                    slot_used_next[fd_reg[SW-1:0]] = 1'b0;
                    res_next.status                = fdt_pkg::ST_OK;
                end
            end
            default: res_next.status = fdt_pkg::ST_INVAL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            row_vld_reg   <= '0;
            slot_used_reg <= '0;
        end
        else if (cmd.execute)
        begin
            in_use_reg    <= in_use_next;
            row_vld_reg   <= row_vld_next;
            slot_used_reg <= slot_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && slot_we)
        begin
            slot_entry_reg[slot_idx] <= addr_reg;
        end
        if (cmd.execute)
        begin
            res_reg <= res_next;
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.execute && mem_we)
        begin
            mem[addr_reg] <= wr_rec;
        end
        if (cmd.capture)
        begin
            rd_rec_reg <= mem[rd_addr];
        end
    end

    assign status        = res_reg.status;
    assign fd_out        = res_reg.fd_out;
    assign entry_out     = res_reg.entry_out;
    assign inode_out     = res_reg.inode_out;
    assign offset_out    = res_reg.offset_out;
    assign can_read      = res_reg.can_read;
    assign can_write     = res_reg.can_write;
    assign append_mode   = res_reg.append_mode;
    assign ref_count     = res_reg.ref_count;
    assign release_inode = res_reg.release_inode;

endmodule

// ===== verif/fdt_checker.sv =====
// Checker for the file descriptor table: predicts every result beat and compares it.
`timescale 1ns / 1ps

module fdt_checker
    import fdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  func,
    input  logic [7:0]  fd,
    input  logic [5:0]  entry,
    input  logic        entry_given,
    input  logic [15:0] inode_id,
    input  logic [1:0]  open_mode,
    input  logic        append,
    input  logic [31:0] file_size,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [4:0]  fd_out,
    input  logic [5:0]  entry_out,
    input  logic [15:0] inode_out,
    input  logic [31:0] offset_out,
    input  logic        can_read,
    input  logic        can_write,
    input  logic        append_mode,
    input  logic [15:0] ref_count,
    input  logic        release_inode,
    output int          mismatches,
    output int          awaiting
);

    typedef struct packed {
        logic [2:0]          status;
        logic [4:0]          fd_out;
        logic [ENTRY_W-1:0]  entry_out;
        logic [INODE_W-1:0]  inode_out;
        logic [OFFSET_W-1:0] offset_out;
        logic                can_read;
        logic                can_write;
        logic                append_mode;
        logic [REFS_W-1:0]   ref_count;
        logic                release_inode;
    } fdt_reply_t;

    // Shadow copy of the file table and the descriptor table.
    logic                entry_open  [FILE_ENTRIES];
    logic [INODE_W-1:0]  entry_ino   [FILE_ENTRIES];
    logic [REFS_W-1:0]   entry_cnt   [FILE_ENTRIES];
    logic [OFFSET_W-1:0] entry_pos   [FILE_ENTRIES];
    logic [ACC_W-1:0]    entry_flags [FILE_ENTRIES];
    logic                slot_busy   [DESCRIPTORS];
    logic [ENTRY_W-1:0]  slot_link   [DESCRIPTORS];

    fdt_reply_t reply_next;
    fdt_reply_t replies_due[$];

    initial
    begin
        mismatches = 0;
        awaiting   = 0;
        for (int i = 0; i < FILE_ENTRIES; i++)
        begin
            entry_open[i]  = 1'b0;
            entry_ino[i]   = '0;
            entry_cnt[i]   = '0;
            entry_pos[i]   = '0;
            entry_flags[i] = '0;
        end
        for (int s = 0; s < DESCRIPTORS; s++)
        begin
            slot_busy[s] = 1'b0;
            slot_link[s] = '0;
        end
    end

    function automatic void describe_entry(input logic [ENTRY_W-1:0] e);
        reply_next.entry_out   = e;
        reply_next.inode_out   = entry_ino[e];
        reply_next.offset_out  = entry_pos[e];
        reply_next.can_read    = entry_flags[e][ACC_READ_BIT];
        reply_next.can_write   = entry_flags[e][ACC_WRITE_BIT];
        reply_next.append_mode = entry_flags[e][ACC_APPEND_BIT];
        reply_next.ref_count   = entry_cnt[e];
    endfunction

    // Freeing an entry hands its inode back only when it held one.
    function automatic void retire_entry(input logic [ENTRY_W-1:0] e);
        if (entry_ino[e] != '0)
        begin
            reply_next.inode_out     = entry_ino[e];
            reply_next.release_inode = 1'b1;
        end
        entry_open[e]  = 1'b0;
        entry_ino[e]   = '0;
        entry_cnt[e]   = '0;
        entry_pos[e]   = '0;
        entry_flags[e] = '0;
    endfunction

    function automatic void predict_table_op(input logic [2:0] op, input logic [7:0] d,
                                             input logic [ENTRY_W-1:0] e, input logic given,
                                             input logic [INODE_W-1:0] ino,
                                             input logic [1:0] mode, input logic app,
                                             input logic [OFFSET_W-1:0] size);
        logic [ENTRY_W-1:0] target;
        logic [ACC_W-1:0]   acc;
        logic               placed;
        int                 slot;

        reply_next        = '0;
        reply_next.status = ST_INVAL;
        placed            = 1'b0;
        slot              = -1;
        case (op)
            FUNC_LOOKUP:
            begin
                reply_next.status = ST_BADF;
                if (d < DESCRIPTORS && slot_busy[d[SLOT_W-1:0]])
                begin
                    target = slot_link[d[SLOT_W-1:0]];
                    if (entry_open[target] && entry_ino[target] != '0)
                    begin
                        reply_next.status = ST_OK;
                        describe_entry(target);
                    end
                end
            end
            FUNC_OPEN:
            begin
                if (ino != '0)
                begin
                    reply_next.status = ST_NFILE;
                    acc = '0;
                    if (mode != MODE_WRONLY)
                        acc[ACC_READ_BIT] = 1'b1;
                    if (mode != MODE_RDONLY)
                        acc[ACC_WRITE_BIT] = 1'b1;
                    acc[ACC_APPEND_BIT] = app;
                    for (int i = 0; i < FILE_ENTRIES; i++)
                    begin
                        if (!placed && !entry_open[i])
                        begin
                            placed         = 1'b1;
                            entry_open[i]  = 1'b1;
                            entry_ino[i]   = ino;
                            entry_cnt[i]   = REFS_W'(1);
                            entry_flags[i] = acc;
                            entry_pos[i]   = app ? size : '0;
                            reply_next.status = ST_OK;
                            describe_entry(ENTRY_W'(i));
                        end
                    end
                end
            end
            FUNC_BIND, FUNC_DUP:
            begin
                if (given)
                begin
                    for (int s = DESCRIPTORS - 1; s >= 0; s--)
                        if (!slot_busy[s])
                            slot = s;
                    if (slot < 0)
                        reply_next.status = ST_MFILE;
                    else
                    begin
                        slot_busy[slot]   = 1'b1;
                        slot_link[slot]   = e;
                        reply_next.status = ST_OK;
                        reply_next.fd_out = 5'(slot);
                        if (op == FUNC_DUP)
                        begin
                            if (entry_cnt[e] != REFS_MAX)
                                entry_cnt[e] = entry_cnt[e] + REFS_W'(1);
                            reply_next.ref_count = entry_cnt[e];
                        end
                    end
                end
            end
            FUNC_PUT:
            begin
                if (given && entry_open[e])
                begin
                    reply_next.status = ST_OK;
                    if (entry_cnt[e] != '0)
                        entry_cnt[e] = entry_cnt[e] - REFS_W'(1);
                    if (entry_cnt[e] == '0)
                        retire_entry(e);
                    reply_next.ref_count = entry_cnt[e];
                end
            end
            FUNC_CLOSE:
            begin
                if (given)
                begin
                    reply_next.status = ST_OK;
                    retire_entry(e);
                end
            end
            FUNC_CLEAR:
            begin
                if (d >= DESCRIPTORS)
                    reply_next.status = ST_BADF;
                else
                begin
                    slot_busy[d[SLOT_W-1:0]] = 1'b0;
                    reply_next.status        = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // A command beat and a result beat may meet at one edge; the command is
    // queued first, so the oldest expectation is always the one compared.
    always @(posedge clk)
    begin
        fdt_reply_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_table_op(func, fd, entry, entry_given, inode_id, open_mode, append,
                                 file_size);
                replies_due.push_back(reply_next);
            end
            if (done)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: result beat with none expected, actual status 0x%0h",
                             $time, status);
                    mismatches++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("fd_out", 32'(want.fd_out), 32'(fd_out));
                    check_field("entry_out", 32'(want.entry_out), 32'(entry_out));
                    check_field("inode_out", 32'(want.inode_out), 32'(inode_out));
                    check_field("offset_out", want.offset_out, offset_out);
                    check_field("can_read", 32'(want.can_read), 32'(can_read));
                    check_field("can_write", 32'(want.can_write), 32'(can_write));
                    check_field("append_mode", 32'(want.append_mode), 32'(append_mode));
                    check_field("ref_count", 32'(want.ref_count), 32'(ref_count));
                    check_field("release_inode", 32'(want.release_inode),
                                32'(release_inode));
                end
            end
            awaiting <= replies_due.size();
        end
    end

endmodule

// ===== verif/tb_file_descriptor_table.sv =====
// Testbench top for the file descriptor table: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_file_descriptor_table;
    import fdt_pkg::*;

    // The one operation code that the package leaves unnamed; the block must reject it.
    localparam logic [2:0] FUNC_UNUSED = 3'd7;

    // Cycles without any accepted command beat or result beat before the run is
    // declared hung. This is far above any correct run, even with the longest
    // sender gap.
    localparam int QUIET_LIMIT = 1000;

    // Four dups on one entry, each followed by a clear, to push its reference count up.
    localparam int HOT_DUPS = 4;

    typedef enum int {
        MIX_FILL,
        MIX_BLEND,
        MIX_DRAIN
    } mix_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    logic [2:0]  func        = FUNC_LOOKUP;
    logic [7:0]  fd          = '0;
    logic [5:0]  entry       = '0;
    logic        entry_given = 1'b0;
    logic [15:0] inode_id    = '0;
    logic [1:0]  open_mode   = MODE_RDONLY;
    logic        append      = 1'b0;
    logic [31:0] file_size   = '0;
    logic        done;
    logic [2:0]  status;
    logic [4:0]  fd_out;
    logic [5:0]  entry_out;
    logic [15:0] inode_out;
    logic [31:0] offset_out;
    logic        can_read;
    logic        can_write;
    logic        append_mode;
    logic [15:0] ref_count;
    logic        release_inode;

    int mismatches;
    int awaiting;
    int quiet_cycles = 0;
    bit gaps_on      = 1'b0;

    file_descriptor_table DUT (.*);

    fdt_checker u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: any accepted command beat or result beat counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Presents one command beat and returns at the edge that accepts it. Start
    // stays high into the next command unless a gap is taken, so back-to-back
    // beats never see start dropped and raised within one time step.
    task automatic issue(input logic [2:0] op, input logic [7:0] d, input logic [5:0] e,
                         input logic g, input logic [15:0] ino, input logic [1:0] m,
                         input logic a, input logic [31:0] sz);
        start       <= 1'b1;
        func        <= op;
        fd          <= d;
        entry       <= e;
        entry_given <= g;
        inode_id    <= ino;
        open_mode   <= m;
        append      <= a;
        file_size   <= sz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // A gap right after acceptance lands while the block is still working
        // on the beat or showing its result, so every phase sees idling.
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    endtask

    // Maps a roll of 0..99 onto an operation through cumulative weights; what
    // is left over past the last weight becomes the unused code.
    function automatic logic [2:0] pick_op(input int roll, input int w_open, input int w_bind,
                                           input int w_dup, input int w_lookup,
                                           input int w_put, input int w_close,
                                           input int w_clear);
        if (roll < w_open)
            return FUNC_OPEN;
        roll -= w_open;
        if (roll < w_bind)
            return FUNC_BIND;
        roll -= w_bind;
        if (roll < w_dup)
            return FUNC_DUP;
        roll -= w_dup;
        if (roll < w_lookup)
            return FUNC_LOOKUP;
        roll -= w_lookup;
        if (roll < w_put)
            return FUNC_PUT;
        roll -= w_put;
        if (roll < w_close)
            return FUNC_CLOSE;
        roll -= w_close;
        if (roll < w_clear)
            return FUNC_CLEAR;
        return FUNC_UNUSED;
    endfunction

    // One random command. The mix decides whether the tables tend to fill up,
    // churn, or empty out; the fields are random in every case, with most
    // descriptors in range and a few deliberately out of it, and every entry in range.
    task automatic random_item(input mix_t mix);
        logic [2:0]  op;
        logic [7:0]  d;
        logic [5:0]  e;
        logic [15:0] ino;
        int          roll;

        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  op = pick_op(roll, 55, 15, 10, 12, 4, 2, 1);
            MIX_BLEND: op = pick_op(roll, 20, 12, 10, 20, 15, 8, 12);
            default:   op = pick_op(roll, 5, 3, 3, 15, 35, 20, 17);
        endcase
        if ($urandom_range(0, 6) == 0)
            d = 8'($urandom_range(32, 255));
        else
            d = 8'($urandom_range(0, 31));
        if ($urandom_range(0, 1) == 0)
            e = 6'($urandom_range(0, 15));
        else
            e = 6'($urandom_range(0, 63));
        case ($urandom_range(0, 19))
            0:       ino = '0;
            1:       ino = 16'hFFFF;
            default: ino = 16'($urandom);
        endcase
        issue(op, d, e, $urandom_range(0, 11) != 0, ino, 2'($urandom), 1'($urandom),
              32'($urandom));
    endtask

    initial
    begin
        logic [5:0] hot;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Lookups on an empty descriptor table, both in range
        // and far out of it.
        gaps_on = 1'b1;
        issue(FUNC_LOOKUP, 8'd0, 6'd0, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_LOOKUP, 8'd255, 6'd0, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        // Open without an inode must be refused; then one open per mode code,
        // with append both ways and the file size at its extremes.
        issue(FUNC_OPEN, 8'd0, 6'd0, 1'b1, 16'd0, MODE_RDWR, 1'b1, 32'hFFFF_FFFF);
        issue(FUNC_OPEN, 8'd0, 6'd0, 1'b1, 16'hFFFF, MODE_RDONLY, 1'b0, 32'hFFFF_FFFF);
        issue(FUNC_OPEN, 8'd0, 6'd0, 1'b1, 16'd1, MODE_WRONLY, 1'b1, 32'hFFFF_FFFF);
        issue(FUNC_OPEN, 8'd0, 6'd0, 1'b1, 16'h1234, MODE_RDWR, 1'b1, 32'd0);
        issue(FUNC_OPEN, 8'd0, 6'd0, 1'b1, 16'h5A5A, MODE_RDWR_ALT, 1'b0, 32'h8000_0001);
        // Bind and dup, including a missing entry and entries that are not open.
        issue(FUNC_BIND, 8'd0, 6'd0, 1'b1, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_BIND, 8'd0, 6'd0, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_DUP, 8'd0, 6'd1, 1'b1, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_BIND, 8'd0, 6'd63, 1'b1, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_DUP, 8'd0, 6'd62, 1'b1, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_DUP, 8'd0, 6'd5, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        // Lookups that pass all checks, one whose entry is not open, one past the table.
        issue(FUNC_LOOKUP, 8'd0, 6'd0, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_LOOKUP, 8'd1, 6'd0, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_LOOKUP, 8'd2, 6'd0, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_LOOKUP, 8'd32, 6'd0, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        // Put down to zero frees the entry; a further put finds it free.
        issue(FUNC_PUT, 8'd0, 6'd1, 1'b1, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_PUT, 8'd0, 6'd1, 1'b1, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_PUT, 8'd0, 6'd1, 1'b1, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_PUT, 8'd0, 6'd2, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        // Force close of an open entry, of a free one, and with no entry.
        issue(FUNC_CLOSE, 8'd0, 6'd0, 1'b1, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_CLOSE, 8'd0, 6'd63, 1'b1, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_CLOSE, 8'd0, 6'd3, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        // Clearing a slot twice is fine; clearing past the table is not.
        issue(FUNC_CLEAR, 8'd0, 6'd0, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_CLEAR, 8'd0, 6'd0, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_CLEAR, 8'd200, 6'd0, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_UNUSED, 8'd0, 6'd0, 1'b1, 16'd7, MODE_RDWR, 1'b1, 32'd0);

        // Open-heavy traffic fills both tables, so the full-table and
        // no-free-descriptor answers come up.
        for (int n = 0; n < 200; n++)
            random_item(MIX_FILL);

        // A stretch of balanced traffic with no idling at all.
        gaps_on = 1'b0;
        for (int n = 0; n < 150; n++)
            random_item(MIX_BLEND);

        // Repeated dups: free every slot, then dup one entry a few times,
        // clearing the slot it took each time so a slot is always free.
        for (int s = 0; s < DESCRIPTORS; s++)
            issue(FUNC_CLEAR, 8'(s), 6'd0, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        hot = 6'($urandom_range(0, 63));
        for (int n = 0; n < HOT_DUPS; n++)
        begin
            issue(FUNC_DUP, 8'd0, hot, 1'b1, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
            issue(FUNC_CLEAR, 8'd0, 6'd0, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        end
        issue(FUNC_BIND, 8'd0, hot, 1'b1, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_LOOKUP, 8'd0, 6'd0, 1'b0, 16'd0, MODE_RDONLY, 1'b0, 32'd0);
        issue(FUNC_PUT, 8'd0, hot, 1'b1, 16'd0, MODE_RDONLY, 1'b0, 32'd0);

        // Close-heavy traffic empties the tables again, with idling back on.
        gaps_on = 1'b1;
        for (int n = 0; n < 150; n++)
            random_item(MIX_DRAIN);

        // The last part runs at full rate.
        gaps_on = 1'b0;
        for (int n = 0; n < 60; n++)
            random_item(MIX_BLEND);
        start <= 1'b0;

        // Drain the outstanding result beats, then give any stray beat time to show
        // up before the verdict.
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/fdt_pkg.sv
design/fdt_ctrl.sv
design/fdt_datapath.sv
design/file_descriptor_table.sv
verif/fdt_checker.sv
verif/tb_file_descriptor_table.sv
